[src/antb_pkg.sv]
// Package: shared types, constants and helper functions of the next-target-bits unit.
package antb_pkg;

    // Widths of the arithmetic
    localparam int TGT_W   = 256;          // target width, bits beyond are dropped on decode
    localparam int DIV_W   = 66;           // |error| (50 bits) with 16 fraction bits appended
    localparam int MANT_W  = 40;           // anchor mantissa times factor
    localparam int SHAMT_W = 11;           // saturated signed exponent shift

    // Cubic 2^x coefficients and rounding term
    localparam logic [47:0] POLY_C1    = 48'd195766423245049;
    localparam logic [29:0] POLY_C2    = 30'd971821376;
    localparam logic [12:0] POLY_C3    = 13'd5127;
    localparam logic [63:0] POLY_ROUND = 64'h0000_8000_0000_0000;

    // Compact encoding of the value one
    localparam logic [31:0] ONE_BITS = 32'h0101_0000;

    typedef enum logic [2:0] {
        CFG_TARGET_SPACING = 3'd0,
        CFG_HALF_LIFE      = 3'd1,
        CFG_ANCHOR_BITS    = 3'd2,
        CFG_LIMIT_BITS     = 3'd3,
        CFG_MIN_DIFF_EN    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OUT_COMPUTED = 3'd0,
        OUT_MIN_DIFF = 3'd1,
        OUT_FIRST    = 3'd2,
        OUT_CLAMPED  = 3'd3,
        OUT_FLOOR    = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        SPEC_NONE    = 2'd0,
        SPEC_MINDIFF = 2'd1,
        SPEC_FIRST   = 2'd2
    } t_spec;

    // Sideband through the divider
    typedef struct packed {
        t_spec spec;
        logic  neg;
    } t_side;

    // Sideband after the exponent is formed
    typedef struct packed {
        t_spec                     spec;
        logic [SHAMT_W-1:0]        shamt;
    } t_tag;

    // Decoded compact number: value = mant << sh
    typedef struct packed {
        logic [22:0] mant;
        logic [7:0]  sh;
    } t_cmpct;

    function automatic t_cmpct decode_compact(input logic [31:0] bits);
        t_cmpct      r;
        logic [7:0]  sz;
        logic [22:0] w;
        logic [4:0]  rs;
        logic [7:0]  shv;
        sz     = bits[31:24];
        w      = bits[22:0];
        r.mant = '0;
        r.sh   = '0;
        rs     = '0;
        shv    = '0;
        if (sz <= 8'd3) begin
            rs     = {2'd3 - sz[1:0], 3'b000};
            r.mant = w >> rs;
        end else if (sz < 8'd35) begin
            shv  = {5'(sz - 8'd3), 3'b000};
            r.sh = shv;
            for (int j = 0; j < 23; j++) begin
                r.mant[j] = w[j] & ((10'(j) + {2'b00, shv}) < 10'(TGT_W));
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] bitlen40(input logic [MANT_W-1:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[src/antb_div_pipe.sv]
// Restoring divider, one quotient bit per pipeline stage.
module antb_div_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [antb_pkg::DIV_W-1:0] i_dividend,
    input  logic [31:0]               i_divisor,
    input  antb_pkg::t_side           i_side,
    output logic                      o_vld,
    output logic [antb_pkg::DIV_W-1:0] o_quot,
    output antb_pkg::t_side           o_side
);

    localparam int W = antb_pkg::DIV_W;

    logic            r_vld  [W];
    logic [W-1:0]    r_dq   [W];     // dividend bits shift out, quotient bits shift in
    logic [31:0]     r_rem  [W-1];
    antb_pkg::t_side r_side [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic            vld_in;
        logic [W-1:0]    dq_in;
        logic [31:0]     rem_in;
        antb_pkg::t_side side_in;
        logic [33:0]     diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign dq_in   = i_dividend;
            assign rem_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign dq_in   = r_dq[k-1];
            assign rem_in  = r_rem[k-1];
            assign side_in = r_side[k-1];
        end

        assign diff = {1'b0, rem_in, dq_in[W-1]} - {2'b00, i_divisor};
        assign ge   = ~diff[33];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[k]   <= {dq_in[W-2:0], ge};
                r_side[k] <= side_in;
            end
        end

        if (k < W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[31:0] : {rem_in[30:0], dq_in[W-1]};
                end
            end
        end
    end

    assign o_vld  = r_vld[W-1];
    assign o_quot = r_dq[W-1];
    assign o_side = r_side[W-1];

endmodule

[src/asert_next_target_bits_unit.sv]
// Top level: pipelined next compact target computation with exponential schedule adjustment.
//
// Each accepted item yields one result: the compact target for the next block and an outcome
// code. The unit is fully pipelined and takes one item per clock while the skid register is
// empty. There are 80 register stages from input to output. The core is the 66-stage
// restoring divider that forms schedule_error * 65536 / half_life one quotient bit per stage;
// around it sit three front stages (product, error, magnitude), one exponent stage, four
// stages for the cubic 2^x polynomial and six stages for scaling, limit compare and compact
// encoding. A one-entry skid register behind the last stage catches a finished result that
// the sink does not take; while the skid holds an item the whole pipeline stalls and o_ready
// back-pressures the source. Configuration registers are written through a plain write port
// (no read-back) and must only change while the unit holds no item. Min-difficulty and
// first-block items ride the pipeline and return the limit.
module asert_next_target_bits_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [47:0] i_time_diff,
    input  logic [31:0] i_height_delta,
    input  logic [47:0] i_new_block_gap,
    input  logic        i_prev_has_parent,
    // result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_bits,
    output logic [2:0]  o_outcome
);

    localparam int MW = antb_pkg::MANT_W;
    localparam int SW = antb_pkg::SHAMT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [16:0] r_target_spacing;
    logic [31:0] r_half_life;
    logic [31:0] r_anchor_bits;
    logic [31:0] r_limit_bits;
    logic        r_min_diff_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_spacing <= 17'd120;
            r_half_life      <= 32'd172800;
            r_anchor_bits    <= '0;
            r_limit_bits     <= '0;
            r_min_diff_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                antb_pkg::CFG_TARGET_SPACING: r_target_spacing <= i_cfg_data[16:0];
                antb_pkg::CFG_HALF_LIFE:      r_half_life      <= i_cfg_data;
                antb_pkg::CFG_ANCHOR_BITS:    r_anchor_bits    <= i_cfg_data;
                antb_pkg::CFG_LIMIT_BITS:     r_limit_bits     <= i_cfg_data;
                antb_pkg::CFG_MIN_DIFF_EN:    r_min_diff_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero half life acts as one
    logic [31:0] half_life_eff;
    assign half_life_eff = (r_half_life == '0) ? 32'd1 : r_half_life;

    // decoded config numbers, to be kept constant by the user while items are in flight
    antb_pkg::t_cmpct anchor_dec;
    antb_pkg::t_cmpct limit_dec;
    logic [5:0]       limit_bl;
    logic [10:0]      limit_bits_len;
    assign anchor_dec     = antb_pkg::decode_compact(r_anchor_bits);
    assign limit_dec      = antb_pkg::decode_compact(r_limit_bits);
    assign limit_bl       = antb_pkg::bitlen40({17'b0, limit_dec.mant});
    assign limit_bits_len = (limit_bl == '0) ? 11'd0 : ({5'b0, limit_bl} + {3'b0, limit_dec.sh});

    // ------------------------------------------------------------------
    // Flow control: whole pipeline moves unless the skid holds an item
    // ------------------------------------------------------------------
    logic en;
    logic r_skid_vld;
    assign en      = ~r_skid_vld;
    assign o_ready = en;

    // ------------------------------------------------------------------
    // S0: spacing * (height_delta + 1), special-case detection
    // ------------------------------------------------------------------
    logic              r0_vld;
    logic [49:0]       r0_prod;
    logic [47:0]       r0_tdiff;
    antb_pkg::t_spec   r0_spec;

    logic [32:0]       h1;
    logic              min_diff_hit;
    antb_pkg::t_spec   n0_spec;
    assign h1           = {1'b0, i_height_delta} + 33'd1;
    // gap > 2 * spacing, signed compare on 49 bits
    assign min_diff_hit = r_min_diff_en &&
                          ($signed({i_new_block_gap[47], i_new_block_gap}) >
                           $signed({31'b0, r_target_spacing, 1'b0}));

    always_comb begin
        if (min_diff_hit) begin
            n0_spec = antb_pkg::SPEC_MINDIFF;
        end else if (!i_prev_has_parent) begin
            n0_spec = antb_pkg::SPEC_FIRST;
        end else begin
            n0_spec = antb_pkg::SPEC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_prod  <= {33'b0, r_target_spacing} * {17'b0, h1};
            r0_tdiff <= i_time_diff;
            r0_spec  <= n0_spec;
        end
    end

    // ------------------------------------------------------------------
    // S1: schedule error d = time_diff - product (51-bit two's complement)
    // ------------------------------------------------------------------
    logic              r1_vld;
    logic [50:0]       r1_d;
    antb_pkg::t_spec   r1_spec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d    <= {{3{r0_tdiff[47]}}, r0_tdiff} - {1'b0, r0_prod};
            r1_spec <= r0_spec;
        end
    end

    // ------------------------------------------------------------------
    // S2: magnitude and sign, the dividend gets 16 fraction bits
    // ------------------------------------------------------------------
    logic              r2_vld;
    logic [49:0]       r2_mag;
    antb_pkg::t_side   r2_side;
    logic [50:0]       d_neg;
    assign d_neg = 51'd0 - r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_mag       <= r1_d[50] ? d_neg[49:0] : r1_d[49:0];
            r2_side.neg  <= r1_d[50];
            r2_side.spec <= r1_spec;
        end
    end

    // ------------------------------------------------------------------
    // Divider: (|d| << 16) / half_life
    // ------------------------------------------------------------------
    logic                       div_vld;
    logic [antb_pkg::DIV_W-1:0] div_quot;
    antb_pkg::t_side            div_side;

    antb_div_pipe u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (r2_vld),
        .i_dividend ({r2_mag, 16'b0}),
        .i_divisor  (half_life_eff),
        .i_side     (r2_side),
        .o_vld      (div_vld),
        .o_quot     (div_quot),
        .o_side     (div_side)
    );

    // ------------------------------------------------------------------
    // E: exponent split into fraction and saturated shift (minus 16)
    // ------------------------------------------------------------------
    logic              rE_vld;
    logic [15:0]       rE_frac;
    antb_pkg::t_tag    rE_tag;

    logic [49:0]       q_int;
    logic [15:0]       q_frac;
    logic [8:0]        q_sat;
    logic              q_fnz;
    logic [SW-1:0]     n_shamt;
    assign q_int  = div_quot[65:16];
    assign q_frac = div_quot[15:0];
    // beyond 511 the result is either the limit or zero, so saturate
    assign q_sat  = (|q_int[49:9]) ? 9'd511 : q_int[8:0];
    assign q_fnz  = |q_frac;
    assign n_shamt = div_side.neg
                   ? (11'd0 - {2'b00, q_sat} - {10'b0, q_fnz} - 11'd16)
                   : ({2'b00, q_sat} - 11'd16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rE_vld <= 1'b0;
        end else if (en) begin
            rE_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rE_frac      <= div_side.neg ? (16'd0 - q_frac) : q_frac;
            rE_tag.spec  <= div_side.spec;
            rE_tag.shamt <= n_shamt;
        end
    end

    // ------------------------------------------------------------------
    // P1..P4: factor = 65536 + ((C1 f + C2 f^2 + C3 f^3 + 2^47) >> 48), mod 2^64
    // ------------------------------------------------------------------
    logic              rP1_vld, rP2_vld, rP3_vld, rP4_vld;
    logic [63:0]       rP1_t1, rP2_t1;
    logic [31:0]       rP1_f2;
    logic [15:0]       rP1_frac;
    logic [63:0]       rP2_t2;
    logic [47:0]       rP2_f3;
    logic [63:0]       rP3_s12, rP3_t3;
    logic [16:0]       rP4_factor;
    antb_pkg::t_tag    rP1_tag, rP2_tag, rP3_tag, rP4_tag;
    logic [63:0]       poly;
    assign poly = rP3_s12 + rP3_t3 + antb_pkg::POLY_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP1_vld <= 1'b0;
            rP2_vld <= 1'b0;
            rP3_vld <= 1'b0;
            rP4_vld <= 1'b0;
        end else if (en) begin
            rP1_vld <= rE_vld;
            rP2_vld <= rP1_vld;
            rP3_vld <= rP2_vld;
            rP4_vld <= rP3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rP1_t1     <= {16'b0, antb_pkg::POLY_C1} * {48'b0, rE_frac};
            rP1_f2     <= {16'b0, rE_frac} * {16'b0, rE_frac};
            rP1_frac   <= rE_frac;
            rP1_tag    <= rE_tag;

            rP2_t1     <= rP1_t1;
            rP2_t2     <= {34'b0, antb_pkg::POLY_C2} * {32'b0, rP1_f2};
            rP2_f3     <= {16'b0, rP1_f2} * {32'b0, rP1_frac};
            rP2_tag    <= rP1_tag;

            rP3_s12    <= rP2_t1 + rP2_t2;
            rP3_t3     <= {51'b0, antb_pkg::POLY_C3} * {16'b0, rP2_f3};
            rP3_tag    <= rP2_tag;

            rP4_factor <= 17'h1_0000 + {1'b0, poly[63:48]};
            rP4_tag    <= rP3_tag;
        end
    end

    // ------------------------------------------------------------------
    // M: anchor mantissa times factor, net exponent = anchor shift + shamt
    // ------------------------------------------------------------------
    logic              rM_vld;
    logic [MW-1:0]     rM_p;
    logic [11:0]       rM_e;
    antb_pkg::t_spec   rM_spec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rM_vld <= 1'b0;
        end else if (en) begin
            rM_vld <= rP4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rM_p    <= {17'b0, anchor_dec.mant} * {23'b0, rP4_factor};
            rM_e    <= {4'b0, anchor_dec.sh} + {rP4_tag.shamt[SW-1], rP4_tag.shamt};
            rM_spec <= rP4_tag.spec;
        end
    end

    // ------------------------------------------------------------------
    // N: overflow check, apply right shifts so value = pm << e
    // ------------------------------------------------------------------
    logic              rN_vld;
    logic [MW-1:0]     rN_pm;
    logic [9:0]        rN_e;
    logic              rN_ovf;
    antb_pkg::t_spec   rN_spec;

    logic [5:0]        p_bl;
    logic [11:0]       p_top;
    logic [11:0]       e_neg;
    assign p_bl  = antb_pkg::bitlen40(rM_p);
    assign p_top = {6'b0, p_bl} + rM_e;
    assign e_neg = 12'd0 - rM_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rN_vld <= 1'b0;
        end else if (en) begin
            rN_vld <= rM_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // top bit past the 320-bit product register
            rN_ovf  <= (rM_p != '0) && !p_top[11] && (p_top > 12'd320);
            if (rM_e[11]) begin
                rN_pm <= (|e_neg[11:6]) ? '0 : (rM_p >> e_neg[5:0]);
                rN_e  <= '0;
            end else begin
                rN_pm <= rM_p;
                rN_e  <= rM_e[9:0];
            end
            rN_spec <= rM_spec;
        end
    end

    // ------------------------------------------------------------------
    // C: bit lengths and left-aligned mantissas for the limit compare
    // ------------------------------------------------------------------
    logic              rC_vld;
    logic [MW-1:0]     rC_pm;
    logic [9:0]        rC_e;
    logic [10:0]       rC_bv;
    logic [MW-1:0]     rC_vn;
    logic [MW-1:0]     rC_ln;
    logic              rC_ovf;
    antb_pkg::t_spec   rC_spec;

    logic [5:0]        pm_bl;
    assign pm_bl = antb_pkg::bitlen40(rN_pm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_vld <= 1'b0;
        end else if (en) begin
            rC_vld <= rN_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rC_pm   <= rN_pm;
            rC_e    <= rN_e;
            rC_bv   <= {5'b0, pm_bl} + {1'b0, rN_e};
            rC_vn   <= rN_pm << (6'd40 - pm_bl);
            rC_ln   <= {limit_dec.mant, 17'b0} << (6'd23 - limit_bl);
            rC_ovf  <= rN_ovf;
            rC_spec <= rN_spec;
        end
    end

    // ------------------------------------------------------------------
    // D: pick computed value, limit or one, and the outcome code
    // ------------------------------------------------------------------
    logic              rD_vld;
    logic [MW-1:0]     rD_m;
    logic [9:0]        rD_e;
    logic [10:0]       rD_b;
    antb_pkg::t_outcome rD_out;

    logic              above_limit;
    logic [MW-1:0]     n_m;
    logic [9:0]        n_e;
    logic [10:0]       n_b;
    antb_pkg::t_outcome n_out;

    assign above_limit = (limit_bits_len == '0) || (rC_bv > limit_bits_len) ||
                         ((rC_bv == limit_bits_len) && (rC_vn > rC_ln));

    always_comb begin
        n_m   = {17'b0, limit_dec.mant};
        n_e   = {2'b0, limit_dec.sh};
        n_b   = limit_bits_len;
        n_out = antb_pkg::OUT_CLAMPED;
        case (rC_spec)
            antb_pkg::SPEC_MINDIFF: n_out = antb_pkg::OUT_MIN_DIFF;
            antb_pkg::SPEC_FIRST:   n_out = antb_pkg::OUT_FIRST;
            default: begin
                if (rC_ovf) begin
                    n_out = antb_pkg::OUT_CLAMPED;
                end else if (rC_pm == '0) begin
                    n_m   = {{(MW-1){1'b0}}, 1'b1};
                    n_e   = '0;
                    n_b   = 11'd1;
                    n_out = antb_pkg::OUT_FLOOR;
                end else if (above_limit) begin
                    n_out = antb_pkg::OUT_CLAMPED;
                end else begin
                    n_m   = rC_pm;
                    n_e   = rC_e;
                    n_b   = rC_bv;
                    n_out = antb_pkg::OUT_COMPUTED;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rD_vld <= 1'b0;
        end else if (en) begin
            rD_vld <= rC_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rD_m   <= n_m;
            rD_e   <= n_e;
            rD_b   <= n_b;
            rD_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // F: compact size and mantissa alignment, a = e + 24 - 8 * size
    // ------------------------------------------------------------------
    logic              rF_vld;
    logic [MW-1:0]     rF_m;
    logic [5:0]        rF_size;
    logic [5:0]        rF_a;
    antb_pkg::t_outcome rF_out;

    logic [11:0]       b_round;
    logic [5:0]        n_size;
    logic [11:0]       n_a;
    assign b_round = {1'b0, rD_b} + 12'd7;
    assign n_size  = b_round[8:3];
    assign n_a     = {2'b0, rD_e} + 12'd24 - {3'b0, n_size, 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rF_vld <= 1'b0;
        end else if (en) begin
            rF_vld <= rD_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rF_m    <= rD_m;
            rF_size <= n_size;
            rF_a    <= n_a[5:0];
            rF_out  <= rD_out;
        end
    end

    // ------------------------------------------------------------------
    // G: 24-bit window, renormalize when the sign bit would be set
    // ------------------------------------------------------------------
    logic              r_out_vld;
    logic [31:0]       r_out_bits;
    logic [2:0]        r_out_outcome;

    logic [5:0]        a_neg;
    logic [MW-1:0]     win;
    logic [23:0]       c24;
    logic [31:0]       n_bits;
    assign a_neg = 6'd0 - rF_a;
    assign win   = rF_a[5] ? (rF_m >> a_neg) : (rF_m << rF_a);
    assign c24   = win[23:0];
    assign n_bits = c24[23] ? {2'b00, rF_size + 6'd1, 8'h00, c24[23:8]}
                            : {2'b00, rF_size, c24};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= rF_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bits    <= n_bits;
            r_out_outcome <= rF_out;
        end
    end

    // ------------------------------------------------------------------
    // Skid register: catches the last stage when the sink stalls
    // ------------------------------------------------------------------
    logic [31:0] r_skid_bits;
    logic [2:0]  r_skid_outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_out_vld && !i_ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_bits    <= r_out_bits;
            r_skid_outcome <= r_out_outcome;
        end
    end

    assign o_valid     = r_skid_vld | r_out_vld;
    assign o_next_bits = r_skid_vld ? r_skid_bits : r_out_bits;
    assign o_outcome   = r_skid_vld ? r_skid_outcome : r_out_outcome;

endmodule

[src/antb_checker.sv]
// Port-level checker for the next-target-bits unit, with its bind.
module antb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_next_bits,
    input logic [2:0]  o_outcome
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_bits) && $stable(o_outcome))
        else $error("stalled result changed");

    // back-pressure only while a result is held
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    // outcome codes stay in range
    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_outcome <= 3'(antb_pkg::OUT_FLOOR))
        else $error("outcome code out of range");

    // floored result is the compact one
    a_floor_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome == 3'(antb_pkg::OUT_FLOOR)) |-> o_next_bits == antb_pkg::ONE_BITS)
        else $error("floored result is not one");

endmodule

bind asert_next_target_bits_unit antb_checker u_antb_checker (.*);

[verif/tb_asert_next_target_bits_unit.sv]
// Testbench for asert_next_target_bits_unit: randomized items checked against an in-bench predictor.
module tb_asert_next_target_bits_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDE  = 320;   // product register width
    localparam int QUIET = 5000;  // watchdog: cycles with no item moving on either side

    typedef struct {
        logic [47:0] td;
        logic [31:0] hd;
        logic [47:0] gap;
        logic        par;
    } t_sched_item;

    typedef struct {
        logic [31:0]        bits;
        antb_pkg::t_outcome oc;
    } t_target_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [47:0] i_time_diff;
    logic [31:0] i_height_delta;
    logic [47:0] i_new_block_gap;
    logic        i_prev_has_parent;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_next_bits;
    logic [2:0]  o_outcome;

    asert_next_target_bits_unit u_top (.*);

    // shadow of the configuration registers
    logic [16:0] sh_spacing;
    logic [31:0] sh_half_life;
    logic [31:0] sh_anchor;
    logic [31:0] sh_limit;
    logic        sh_min_diff;

    t_sched_item pending_items[$];
    t_target_res expected_targets[$];
    t_sched_item held_item;
    int          n_errors;
    bit          calm;       // last part of the run: no idling on either side
    int          wd_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic [WIDE-1:0] compact_to_target(input logic [31:0] b);
        logic [WIDE-1:0] r;
        int sz;
        sz = b[31:24];
        r = '0;
        r[22:0] = b[22:0];
        if (sz <= 3) begin
            r = r >> (8 * (3 - sz));
        end else begin
            r = r << (8 * (sz - 3));
            r[WIDE-1:256] = '0;   // bits past the target width are dropped
        end
        return r;
    endfunction

    function automatic int target_bitlen(input logic [WIDE-1:0] x);
        int n;
        n = 0;
        for (int i = 0; i < WIDE; i++) begin
            if (x[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] target_to_compact(input logic [WIDE-1:0] x);
        int              size;
        logic [WIDE-1:0] t;
        logic [31:0]     c;
        size = (target_bitlen(x) + 7) / 8;
        if (size <= 3) begin
            c = x[31:0] << (8 * (3 - size));
        end else begin
            t = x >> (8 * (size - 3));
            c = t[31:0];
        end
        c &= 32'h00ff_ffff;
        if (c[23]) begin
            c = c >> 8;
            size++;
        end
        return c | (32'(size) << 24);
    endfunction

    function automatic t_target_res predict_next_bits(input t_sched_item it);
        t_target_res         r;
        longint              td, gap, ts, d, shifts;
        longint unsigned     mag, h, q1, r1, t, frac, poly;
        logic [31:0]         factor;
        logic [WIDE-1:0]     limit, tgt;
        int                  bl;
        td    = longint'($signed(it.td));
        gap   = longint'($signed(it.gap));
        ts    = longint'({47'd0, sh_spacing});
        limit = compact_to_target(sh_limit);
        r.oc  = antb_pkg::OUT_COMPUTED;
        if (sh_min_diff && gap > 2 * ts) begin
            r.bits = target_to_compact(limit);
            r.oc   = antb_pkg::OUT_MIN_DIFF;
            return r;
        end
        if (!it.par) begin
            r.bits = target_to_compact(limit);
            r.oc   = antb_pkg::OUT_FIRST;
            return r;
        end
        // schedule error -> fixed-point exponent, floor division toward -inf
        d   = td - ts * (longint'({32'd0, it.hd}) + 1);
        mag = (d < 0) ? longint'(-d) : longint'(d);
        h   = (sh_half_life != 0) ? longint'({32'd0, sh_half_life}) : 1;
        q1  = mag / h;
        r1  = mag % h;
        t   = (r1 << 16) / h;
        if (d >= 0) begin
            shifts = longint'(q1);
            frac   = t;
        end else begin
            shifts = -longint'(q1) - ((t != 0) ? 1 : 0);
            frac   = (t != 0) ? 65536 - t : 0;
        end
        poly = 64'd195766423245049 * frac + 64'd971821376 * frac * frac
             + 64'd5127 * frac * frac * frac + (64'd1 << 47);
        factor = 32'd65536 + 32'(poly >> 48);
        tgt    = compact_to_target(sh_anchor);
        tgt    = tgt * {288'd0, factor};
        shifts -= 16;
        if (shifts <= 0) begin
            tgt = (-shifts >= WIDE) ? '0 : tgt >> (-shifts);
        end else begin
            bl = target_bitlen(tgt);
            if (bl != 0 && (shifts >= WIDE || longint'(bl) + shifts > WIDE)) begin
                r.bits = target_to_compact(limit);
                r.oc   = antb_pkg::OUT_CLAMPED;
                return r;
            end
            tgt = (shifts >= WIDE) ? '0 : tgt << shifts;
        end
        if (target_bitlen(tgt) == 0) begin
            tgt    = '0;
            tgt[0] = 1'b1;
            r.oc   = antb_pkg::OUT_FLOOR;
        end else if (tgt > limit) begin
            tgt  = limit;
            r.oc = antb_pkg::OUT_CLAMPED;
        end
        r.bits = target_to_compact(tgt);
        return r;
    endfunction

    // ---------------------------------------------------------------- driver
    int src_gap;
    always @(posedge i_clk) begin
        t_sched_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_targets.push_back(predict_next_bits(held_item));
            end
            if (!i_valid || o_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    held_item         <= it;
                    i_time_diff       <= it.td;
                    i_height_delta    <= it.hd;
                    i_new_block_gap   <= it.gap;
                    i_prev_has_parent <= it.par;
                    i_valid           <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        src_gap = $urandom_range(1, 4);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    int sink_stall;
    int sink_hold;
    int n_results;
    always @(posedge i_clk) begin
        t_target_res e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            sink_stall = 0;
            sink_hold  = 0;
            n_results  = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_targets.size() == 0) begin
                    $error("result item with nothing expected: next_bits %h outcome %0d",
                           o_next_bits, o_outcome);
                    n_errors++;
                end else begin
                    e = expected_targets.pop_front();
                    if (o_next_bits !== e.bits) begin
                        $error("next_bits: expected %h actual %h", e.bits, o_next_bits);
                        n_errors++;
                    end
                    if (o_outcome !== e.oc) begin
                        $error("outcome: expected %0d actual %0d", e.oc, o_outcome);
                        n_errors++;
                    end
                end
                n_results++;
                // long back-pressure: pipeline fills and stalls the source
                if (n_results == 200) begin
                    sink_hold = 400;
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_ready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) begin
                    sink_stall = $urandom_range(1, 4);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            wd_cnt = 0;
        end else begin
            wd_cnt++;
            if (wd_cnt >= QUIET) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic write_cfg(input antb_pkg::t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            antb_pkg::CFG_TARGET_SPACING: sh_spacing   = data[16:0];
            antb_pkg::CFG_HALF_LIFE:      sh_half_life = data;
            antb_pkg::CFG_ANCHOR_BITS:    sh_anchor    = data;
            antb_pkg::CFG_LIMIT_BITS:     sh_limit     = data;
            default:                      sh_min_diff  = data[0];
        endcase
    endtask

    task automatic setup(input logic [16:0] ts, input logic [31:0] hl, input logic [31:0] anc,
                         input logic [31:0] lim, input logic mde);
        write_cfg(antb_pkg::CFG_TARGET_SPACING, {15'd0, ts});
        write_cfg(antb_pkg::CFG_HALF_LIFE, hl);
        write_cfg(antb_pkg::CFG_ANCHOR_BITS, anc);
        write_cfg(antb_pkg::CFG_LIMIT_BITS, lim);
        write_cfg(antb_pkg::CFG_MIN_DIFF_EN, {31'd0, mde});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic [47:0] td, input logic [31:0] hd,
                             input logic [47:0] gap, input logic par);
        t_sched_item it;
        it.td = td; it.hd = hd; it.gap = gap; it.par = par;
        pending_items.push_back(it);
    endtask

    // mostly on-schedule items with an error spread over a few hundred half lives
    task automatic push_random(input int n);
        longint h, e, ts;
        logic [31:0] hd;
        logic [47:0] td, gap;
        for (int i = 0; i < n; i++) begin
            ts = longint'(sh_spacing);
            h  = (sh_half_life != 0) ? longint'({32'd0, sh_half_life}) : 1;
            hd = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 2000)) : $urandom;
            e  = longint'($urandom_range(0, 300)) * h + longint'({32'd0, $urandom}) % h;
            if ($urandom_range(0, 1)) e = -e;
            td = 48'(ts * (longint'({32'd0, hd}) + 1) + e);
            if ($urandom_range(0, 5) == 0) td = 48'({$urandom, $urandom});
            gap = 48'(longint'($urandom_range(0, 4 * sh_spacing)) - 10);
            if ($urandom_range(0, 7) == 0) gap = 48'({$urandom, $urandom});
            push_item(td, hd, gap, $urandom_range(0, 15) != 0);
        end
    endtask

    // sampled at the falling edge so that the driver's updates have settled
    task automatic drain;
        while (pending_items.size() > 0 || i_valid || expected_targets.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (100) @(posedge i_clk);   // pipeline latency margin
    endtask

    initial begin
        n_errors          = 0;
        calm              = 1'b0;
        wd_cnt            = 0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = antb_pkg::CFG_TARGET_SPACING;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_ready           = 1'b0;
        i_time_diff       = '0;
        i_height_delta    = '0;
        i_new_block_gap   = '0;
        i_prev_has_parent = 1'b0;
        sh_spacing        = 17'd120;
        sh_half_life      = 32'd172800;
        sh_anchor         = '0;
        sh_limit          = '0;
        sh_min_diff       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: special cases and field extremes
        setup(17'd120, 32'd172800, 32'h1d00ffff, 32'h1d00ffff, 1'b1);
        push_item(48'd120, 32'd0, 48'd60, 1'b0);                    // first block
        push_item(48'd120, 32'd0, 48'd241, 1'b1);                   // min-difficulty
        push_item(48'd120, 32'd0, 48'd240, 1'b1);                   // gap right at the bound
        push_item(48'd120, 32'd0, 48'd100, 1'b1);                   // on schedule
        push_item(48'h7fff_ffff_ffff, 32'd0, 48'd0, 1'b1);          // max time_diff: clamp
        push_item(48'h8000_0000_0000, 32'd0, 48'd0, 1'b1);          // min time_diff: floor
        push_item(48'd0, 32'hffff_ffff, 48'h8000_0000_0000, 1'b1);  // max height
        push_item(48'hffff_ffff_ffff, 32'hffff_ffff, 48'h7fff_ffff_ffff, 1'b0);
        push_item(48'd0, 32'd0, 48'hffff_ffff_ffff, 1'b1);
        push_item(48'd120 - 48'd1000, 32'd0, 48'd0, 1'b1);          // small negative error
        push_item(48'd240 + 48'd172800, 32'd1, 48'd1, 1'b1);        // one half life late
        push_item(48'd240 - 48'd172800, 32'd1, 48'd1, 1'b1);        // one half life early
        push_random(200);
        drain();

        setup(17'd1, 32'd1, 32'h1c0fffff, 32'h207fffff, 1'b0);     // shortest spacing, half life
        push_item(48'd5, 32'd3, 48'd1000, 1'b1);
        push_random(200);
        drain();
        setup(17'd86400, 32'hffff_ffff, 32'h1d00ffff, 32'h1d00ffff, 1'b1);
        push_random(200);
        drain();
        setup(17'd600, 32'd0, 32'h00000000, 32'h1d00ffff, 1'b0);   // zero half life, zero anchor
        push_random(200);
        drain();
        setup(17'd120, 32'd3600, 32'h2100ffff, 32'h1d00ffff, 1'b0); // anchor above limit
        push_random(200);
        drain();
        setup(17'($urandom_range(1, 86400)), $urandom, 32'hff7fffff, 32'hffffffff, 1'b1);
        push_random(200);
        drain();
        setup(17'd30, 32'd172800, 32'h03800001, 32'h00000000, 1'b0); // sign bit, zero limit
        push_random(200);
        drain();

        calm = 1'b1;
        setup(17'($urandom_range(1, 86400)), 32'($urandom_range(1, 1000000)),
              {8'($urandom_range(3, 34)), 24'($urandom)} & 32'hff7fffff, 32'h207fffff,
              1'($urandom_range(0, 1)));
        push_random(200);
        drain();

        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
